FILE: sv/ck_pkg.sv
// shared types and constants for the chroma keyer
// used by ck_front, ck_queue, ck_back and chroma_key_alpha_matte
package ck_pkg;

    localparam logic [7:0] PIX_MAX = 8'd255;

    // request kinds carried in tuser[1:0]
    localparam logic [1:0] REQ_LEARN   = 2'd0;
    localparam logic [1:0] REQ_MEASURE = 2'd1;
    localparam logic [1:0] REQ_OUTPUT  = 2'd2;

    // configuration register indexes
    localparam logic CFG_BG_THRESHOLD = 1'b0;
    localparam logic CFG_FG_THRESHOLD = 1'b1;

    // one output pixel handed from the front to the back
    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] num;    // 255 * spill difference
        logic [7:0]  range;  // spill_max - spill_min, zero when empty
        logic        fg;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

FILE: sv/chroma_key_alpha_matte.sv
// top level of the chroma keyer: config registers, front, job queue, back
// depends on ck_pkg, ck_front, ck_queue, ck_back
//
//   channel   dir   tdata / data                        tuser / index
//   s_*       in    chan_a, chan_b, chan_key (24 bit)   req_type, restart
//   m_*       out   key_out, alpha_out (16 bit)         is_foreground
//   cfg_*     in    threshold value (8 bit)             0 bg, 1 fg threshold
//
// learn and measure words are taken one per cycle while the queue has room.
// an output word goes straight to the result in the back when background or the spill
// range is zero; otherwise it first passes through the 16-step serial divider.
// the job queue lets the front run ahead of the divider by QUEUE_DEPTH words.
// reset sets empty bounds and empty spill stats at once, no clearing pass.
// a held result stalls the back only; the front keeps going until the queue fills.
module chroma_key_alpha_matte #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // chan_a, chan_b, chan_key
    input  logic [2:0]  s_tuser,    // req_type, restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // key_out, alpha_out
    output logic [0:0]  m_tuser,    // is_foreground
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]   bg_thr_reg, bg_thr_next;
    logic [7:0]   fg_thr_reg, fg_thr_next;

    logic         accept;
    logic         job_push;
    ck_pkg::job_t job_in;
    ck_pkg::job_t job_head;
    logic         job_valid;
    logic         job_pop;
    logic         q_full;
    logic [7:0]   key_out;
    logic [7:0]   alpha_out;
    logic         is_fg;

    always_comb
    begin
        bg_thr_next = bg_thr_reg;
        fg_thr_next = fg_thr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ck_pkg::CFG_BG_THRESHOLD: bg_thr_next = cfg_data;
                ck_pkg::CFG_FG_THRESHOLD: fg_thr_next = cfg_data;
                default:                  bg_thr_next = bg_thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_thr_reg <= 8'd0;
            fg_thr_reg <= ck_pkg::PIX_MAX;
        end
        else
        begin
            bg_thr_reg <= bg_thr_next;
            fg_thr_reg <= fg_thr_next;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ck_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (s_tuser[1:0]),
        .restart  (s_tuser[2]),
        .chan_a   (s_tdata[7:0]),
        .chan_b   (s_tdata[15:8]),
        .chan_key (s_tdata[23:16]),
        .job_push (job_push),
        .job      (job_in)
    );

    ck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .head      (job_head),
        .not_empty (job_valid),
        .full      (q_full)
    );

    ck_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job_head),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .bg_threshold  (bg_thr_reg),
        .fg_threshold  (fg_thr_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .key_out       (key_out),
        .alpha_out     (alpha_out),
        .is_foreground (is_fg)
    );

    assign m_tdata = {alpha_out, key_out};
    assign m_tuser = is_fg;

endmodule

FILE: sv/ck_front.sv
// front end: classifies pixels, keeps background bounds and spill stats
// depends on ck_pkg
module ck_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        req_type,
    input  logic              restart,
    input  logic [7:0]        chan_a,
    input  logic [7:0]        chan_b,
    input  logic [7:0]        chan_key,
    output logic              job_push,
    output ck_pkg::job_t      job
);

    logic [7:0] bg_low_reg  [3];
    logic [7:0] bg_high_reg [3];
    logic [7:0] bg_low_next [3];
    logic [7:0] bg_high_next[3];
    logic [7:0] spill_max_reg, spill_max_next;
    logic [7:0] spill_min_reg, spill_min_next;

    logic [7:0] px [3];
    logic [7:0] ab_max;
    logic [7:0] key;
    logic [7:0] diff;
    logic       fg;
    logic [7:0] low_base;
    logic [7:0] high_base;
    logic [7:0] smax_base;
    logic [7:0] smin_base;

    assign px[0] = chan_a;
    assign px[1] = chan_b;
    assign px[2] = chan_key;

    assign ab_max = (chan_a > chan_b) ? chan_a : chan_b;
    assign key    = (ab_max < chan_key) ? ab_max : chan_key;
    assign diff   = chan_key - key;

    always_comb
    begin
        fg = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            if (px[c] < bg_low_reg[c] || px[c] > bg_high_reg[c])
                fg = 1'b1;
        end
    end

    always_comb
    begin
        low_base  = 8'd0;
        high_base = 8'd0;
        for (int c = 0; c < 3; c++)
        begin
            bg_low_next[c]  = bg_low_reg[c];
            bg_high_next[c] = bg_high_reg[c];
            if (accept && req_type == ck_pkg::REQ_LEARN)
            begin
                low_base  = restart ? ck_pkg::PIX_MAX : bg_low_reg[c];
                high_base = restart ? 8'd0 : bg_high_reg[c];
                bg_low_next[c]  = (px[c] < low_base) ? px[c] : low_base;
                bg_high_next[c] = (px[c] > high_base) ? px[c] : high_base;
            end
        end
    end

    // restart clears the stats even when the pixel is background
    always_comb
    begin
        smax_base      = restart ? 8'd0 : spill_max_reg;
        smin_base      = restart ? ck_pkg::PIX_MAX : spill_min_reg;
        spill_max_next = spill_max_reg;
        spill_min_next = spill_min_reg;
        if (accept && req_type == ck_pkg::REQ_MEASURE)
        begin
            spill_max_next = smax_base;
            spill_min_next = smin_base;
            if (fg)
            begin
                spill_max_next = (diff > smax_base) ? diff : smax_base;
                spill_min_next = (diff < smin_base) ? diff : smin_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                bg_low_reg[c]  <= ck_pkg::PIX_MAX;
                bg_high_reg[c] <= 8'd0;
            end
            spill_max_reg <= 8'd0;
            spill_min_reg <= ck_pkg::PIX_MAX;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                bg_low_reg[c]  <= bg_low_next[c];
                bg_high_reg[c] <= bg_high_next[c];
            end
            spill_max_reg <= spill_max_next;
            spill_min_reg <= spill_min_next;
        end
    end

    assign job_push  = accept && req_type == ck_pkg::REQ_OUTPUT;
    assign job.key   = key;
    assign job.num   = {diff, 8'd0} - {8'd0, diff};
    assign job.range = (spill_max_reg >= spill_min_reg) ? (spill_max_reg - spill_min_reg)
                                                        : 8'd0;
    assign job.fg    = fg;

endmodule

FILE: sv/ck_queue.sv
// small fifo of output jobs between front and back
// depends on ck_pkg
module ck_queue #(
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ck_pkg::job_t push_data,
    input  logic         pop,
    output ck_pkg::job_t head,
    output logic         not_empty,
    output logic         full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ck_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = count_reg != CNT_W'(0);
    assign full      = count_reg == CNT_W'(DEPTH);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/ck_back.sv
// back end: serial alpha divider, thresholds and output register
// depends on ck_pkg
module ck_back (
    input  logic         clk,
    input  logic         rst_n,
    input  ck_pkg::job_t job,
    input  logic         job_valid,
    output logic         job_pop,
    input  logic [7:0]   bg_threshold,
    input  logic [7:0]   fg_threshold,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   key_out,
    output logic [7:0]   alpha_out,
    output logic         is_foreground
);

    localparam int QUO_W = 16;

    ck_pkg::bk_state_t state_reg, state_next;

    logic [7:0]       key_reg, key_next;
    logic             fg_reg, fg_next;
    logic [7:0]       alpha_reg, alpha_next;
    logic [7:0]       rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] num_reg, num_next;
    logic [7:0]       div_reg, div_next;
    logic [3:0]       cnt_reg, cnt_next;

    logic [8:0]       rem_sh;
    logic             q_bit;
    logic [8:0]       rem_sub;
    logic [QUO_W-1:0] quo_step;

    function automatic logic [7:0] apply_thr(input logic [7:0] a,
                                             input logic [7:0] bg,
                                             input logic [7:0] fgt);
        logic [7:0] r;
        r = (a >= fgt) ? ck_pkg::PIX_MAX : a;
        if (r <= bg)
            r = 8'd0;
        return r;
    endfunction

    function automatic logic [7:0] quo_to_alpha(input logic [QUO_W-1:0] q);
        logic [7:0] r;
        // quotient above 255 means the alpha went negative
        if (q > QUO_W'(ck_pkg::PIX_MAX))
            r = 8'd0;
        else
            r = ck_pkg::PIX_MAX - q[7:0];
        return r;
    endfunction

    // one restoring step per cycle
    assign rem_sh   = {rem_reg, num_reg[QUO_W-1]};
    assign q_bit    = rem_sh >= {1'b0, div_reg};
    assign rem_sub  = rem_sh - {1'b0, div_reg};
    assign quo_step = {quo_reg[QUO_W-2:0], q_bit};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ck_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    if (!job.fg || job.range == 8'd0)
                        state_next = ck_pkg::BK_DONE;
                    else
                        state_next = ck_pkg::BK_DIV;
                end
            end
            ck_pkg::BK_DIV:
            begin
                if (cnt_reg == 4'(QUO_W - 1))
                    state_next = ck_pkg::BK_DONE;
            end
            ck_pkg::BK_DONE:
            begin
                if (out_ready)
                    state_next = ck_pkg::BK_IDLE;
            end
            default:
                state_next = ck_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop   = 1'b0;
        out_valid = 1'b0;
        key_next  = key_reg;
        fg_next   = fg_reg;
        alpha_next = alpha_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            ck_pkg::BK_IDLE:
            begin
                job_pop = job_valid;
                if (job_valid)
                begin
                    key_next = job.key;
                    fg_next  = job.fg;
                    rem_next = 8'd0;
                    quo_next = '0;
                    num_next = job.num;
                    div_next = job.range;
                    cnt_next = 4'd0;
                    if (!job.fg)
                        alpha_next = 8'd0;
                    else
                        alpha_next = apply_thr(ck_pkg::PIX_MAX, bg_threshold, fg_threshold);
                end
            end
            ck_pkg::BK_DIV:
            begin
                rem_next = q_bit ? rem_sub[7:0] : rem_sh[7:0];
                quo_next = quo_step;
                num_next = {num_reg[QUO_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                alpha_next = apply_thr(quo_to_alpha(quo_step), bg_threshold, fg_threshold);
            end
            ck_pkg::BK_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ck_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        fg_reg    <= fg_next;
        alpha_reg <= alpha_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        num_reg   <= num_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
    end

    assign key_out       = key_reg;
    assign alpha_out     = alpha_reg;
    assign is_foreground = fg_reg;

endmodule

FILE: sv/ck_checker.sv
// port-level checks on the chroma keyer output channel
// bound to chroma_key_alpha_matte; depends on nothing else
module ck_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // background pixels are fully transparent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == 1'b0 |-> m_tdata[15:8] == 8'd0)
        else $error("background pixel with nonzero alpha");

    // nothing is offered straight out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    // a taken word is never offered again on the next cycle without work
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("output valid held after word taken");

endmodule

bind chroma_key_alpha_matte ck_checker u_ck_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
